// ----- rtl/core/bole_pkg.sv -----
`default_nettype none

package bole_pkg;

  localparam int DEPTH       = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int INDEX_W     = $clog2(DEPTH);
  localparam int COUNT_W     = $clog2(DEPTH + 1);
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd4;
  localparam logic [OP_W-1:0] OP_FIND       = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic               push_front;
    logic               push_tail;
    logic               pop_front;
    logic               remove;
    logic [COUNT_W-1:0] count;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/bole_cell.sv -----
`default_nettype none

module bole_cell (
  input  wire                               clk,
  input  wire  bole_pkg::cell_ctrl_t        ctrl,
  input  wire  [bole_pkg::COUNT_W-1:0]      position,
  input  wire  [bole_pkg::VALUE_WIDTH-1:0]  item_value,
  input  wire  [bole_pkg::VALUE_WIDTH-1:0]  left_value,
  input  wire  [bole_pkg::VALUE_WIDTH-1:0]  right_value,
  input  wire                               hit_in,
  output logic [bole_pkg::VALUE_WIDTH-1:0]  entry,
  output logic                              hit_out
);

  logic [bole_pkg::VALUE_WIDTH-1:0] entry_next;
  logic                             occupied;
  logic                             match;

  assign occupied = position < ctrl.count;
  assign match    = occupied && (entry == item_value);
  assign hit_out  = hit_in | match;

  always_comb begin
    entry_next = entry;
    priority if (ctrl.push_front) begin
      entry_next = left_value;
    end else if (ctrl.push_tail && (position == ctrl.count)) begin
      entry_next = item_value;
    end else if (ctrl.pop_front) begin
      entry_next = right_value;
    end else if (ctrl.remove && hit_out) begin
      entry_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// ----- rtl/core/bounded_ordered_list_engine.sv -----
// Ordered double-ended store of up to 64 non-zero 32-bit words.
// A request on the input channel (in_valid, in_ready, operation, item_value)
// carries one operation: push front or back, pop front or back, remove the
// first equal entry, find a value, or clear. Each request yields exactly one
// result on the output channel (out_valid, out_ready, status, popped_value,
// found, entry_count), which reports the entry count after the operation.
// The words sit in a row of cells, one word per cell; every cell compares
// its word against the request value and hands its word to a neighbor on a
// shift, so all positions move in the same cycle.
// After a request is accepted it is registered, and the cell row then compares
// and shifts while the result register and out_valid are loaded; a new request
// is not taken until the held one has moved into the result register. If the
// receiver stalls, one request more is accepted and held until the result
// register frees up, then input stalls too.
// Reset empties the store and drops any pending request or result; the word
// storage itself is not cleared.
`default_nettype none

module bounded_ordered_list_engine (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  [bole_pkg::OP_W-1:0]          operation,
  input  wire  [bole_pkg::VALUE_WIDTH-1:0]   item_value,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [bole_pkg::STATUS_W-1:0]      status,
  output logic [bole_pkg::VALUE_WIDTH-1:0]   popped_value,
  output logic                               found,
  output logic [bole_pkg::COUNT_W-1:0]       entry_count
);

  logic                               busy;
  logic [bole_pkg::OP_W-1:0]          op_q;
  logic [bole_pkg::VALUE_WIDTH-1:0]   value_q;
  logic [bole_pkg::COUNT_W-1:0]       count;
  logic [bole_pkg::COUNT_W-1:0]       count_next;
  logic                               commit;
  logic                               zero;
  logic                               full;
  logic                               empty;
  logic [bole_pkg::INDEX_W-1:0]       tail_idx;
  logic [bole_pkg::STATUS_W-1:0]      status_next;
  logic [bole_pkg::VALUE_WIDTH-1:0]   popped_next;
  logic                               found_next;
  logic                               do_push_front;
  logic                               do_push_tail;
  logic                               do_pop_front;
  logic                               do_remove;
  bole_pkg::cell_ctrl_t               ctrl;
  logic [bole_pkg::VALUE_WIDTH-1:0]   cell_value [bole_pkg::DEPTH];
  logic [bole_pkg::DEPTH:0]           hit;

  assign in_ready = !busy;
  assign commit   = busy && (!out_valid || out_ready);
  assign zero     = (value_q == '0);
  assign full     = (count == bole_pkg::COUNT_W'(bole_pkg::DEPTH));
  assign empty    = (count == '0);
  assign tail_idx = bole_pkg::INDEX_W'(count - bole_pkg::COUNT_W'(1));

  always_comb begin
    status_next   = bole_pkg::ST_OK;
    popped_next   = '0;
    found_next    = 1'b0;
    count_next    = count;
    do_push_front = 1'b0;
    do_push_tail  = 1'b0;
    do_pop_front  = 1'b0;
    do_remove     = 1'b0;
    unique case (op_q)
      bole_pkg::OP_PUSH_FRONT, bole_pkg::OP_PUSH_BACK: begin
        if (zero) begin
          status_next = bole_pkg::ST_ZERO;
        end else if (full) begin
          status_next = bole_pkg::ST_FULL;
        end else begin
          do_push_front = (op_q == bole_pkg::OP_PUSH_FRONT);
          do_push_tail  = (op_q == bole_pkg::OP_PUSH_BACK);
          count_next    = count + bole_pkg::COUNT_W'(1);
        end
      end
      bole_pkg::OP_POP_FRONT, bole_pkg::OP_POP_BACK: begin
        if (empty) begin
          status_next = bole_pkg::ST_EMPTY;
        end else begin
          if (op_q == bole_pkg::OP_POP_FRONT) begin
            popped_next  = cell_value[0];
            do_pop_front = 1'b1;
          end else begin
            popped_next = cell_value[tail_idx];
          end
          count_next = count - bole_pkg::COUNT_W'(1);
        end
      end
      bole_pkg::OP_REMOVE: begin
        if (zero) begin
          status_next = bole_pkg::ST_ZERO;
        end else if (hit[bole_pkg::DEPTH]) begin
          found_next = 1'b1;
          do_remove  = 1'b1;
          count_next = count - bole_pkg::COUNT_W'(1);
        end
      end
      bole_pkg::OP_FIND: begin
        if (zero) begin
          status_next = bole_pkg::ST_ZERO;
        end else begin
          found_next = hit[bole_pkg::DEPTH];
        end
      end
      bole_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctrl.push_front = commit && do_push_front;
    ctrl.push_tail  = commit && do_push_tail;
    ctrl.pop_front  = commit && do_pop_front;
    ctrl.remove     = commit && do_remove;
    ctrl.count      = count;
  end

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < bole_pkg::DEPTH; i++) begin : g_cell
    logic [bole_pkg::VALUE_WIDTH-1:0] left_value;
    logic [bole_pkg::VALUE_WIDTH-1:0] right_value;

    if (i == 0) begin : g_head
      assign left_value = value_q;
    end else begin : g_body
      assign left_value = cell_value[i-1];
    end

    if (i == bole_pkg::DEPTH - 1) begin : g_tail
      assign right_value = '0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    bole_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .position    (bole_pkg::COUNT_W'(i)),
      .item_value  (value_q),
      .left_value  (left_value),
      .right_value (right_value),
      .hit_in      (hit[i]),
      .entry       (cell_value[i]),
      .hit_out     (hit[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (in_valid && in_ready) begin
        busy <= 1'b1;
      end else if (commit) begin
        busy <= 1'b0;
      end
      if (commit) begin
        out_valid <= 1'b1;
        count     <= count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q    <= operation;
      value_q <= item_value;
    end
    if (commit) begin
      status       <= status_next;
      popped_value <= popped_next;
      found        <= found_next;
      entry_count  <= count_next;
    end
  end

endmodule

`default_nettype wire

// ----- dv/bole_list_checker.sv -----
module bole_list_checker
  import bole_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  input  wire                   in_ready,
  input  wire  [OP_W-1:0]       operation,
  input  wire  [VALUE_WIDTH-1:0] item_value,
  input  wire                   out_valid,
  input  wire                   out_ready,
  input  wire  [STATUS_W-1:0]   status,
  input  wire  [VALUE_WIDTH-1:0] popped_value,
  input  wire                   found,
  input  wire  [COUNT_W-1:0]    entry_count,
  output int                    mismatches,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [VALUE_WIDTH-1:0] popped;
    logic                   found;
    logic [COUNT_W-1:0]     count;
  } list_result_t;

  logic [VALUE_WIDTH-1:0] held_words[$];
  list_result_t           predicted_results[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                 input logic [VALUE_WIDTH-1:0] value);
    list_result_t res;
    int           hit_at;
    res    = '0;
    hit_at = -1;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (value == '0) begin
          res.status = ST_ZERO;
        end else if (held_words.size() >= DEPTH) begin
          res.status = ST_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          held_words.push_front(value);
        end else begin
          held_words.insert(held_words.size(), value);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (held_words.size() == 0) begin
          res.status = ST_EMPTY;
        end else if (op == OP_POP_FRONT) begin
          res.popped = held_words.pop_front();
        end else begin
          res.popped = held_words[held_words.size() - 1];
          held_words.delete(held_words.size() - 1);
        end
      end
      OP_REMOVE, OP_FIND: begin
        if (value == '0) begin
          res.status = ST_ZERO;
        end else begin
          for (int i = 0; i < held_words.size(); i++) begin
            if (hit_at < 0 && held_words[i] == value) begin
              hit_at = i;
            end
          end
          if (hit_at >= 0) begin
            res.found = 1'b1;
            if (op == OP_REMOVE) begin
              held_words.delete(hit_at);
            end
          end
        end
      end
      OP_CLEAR: begin
        held_words.delete();
      end
      default: begin
      end
    endcase
    res.count = COUNT_W'(held_words.size());
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [VALUE_WIDTH-1:0] got,
                                 input logic [VALUE_WIDTH-1:0] want);
    if (mismatches < 40) begin
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      held_words.delete();
      predicted_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        want = apply_list_op(operation, item_value);
        predicted_results.insert(predicted_results.size(), want);
      end
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result with no request pending", popped_value, '0);
        end else begin
          want = predicted_results.pop_front();
          if (status !== want.status) begin
            report_mismatch("status", status, want.status);
          end
          if (popped_value !== want.popped) begin
            report_mismatch("popped_value", popped_value, want.popped);
          end
          if (found !== want.found) begin
            report_mismatch("found", found, want.found);
          end
          if (entry_count !== want.count) begin
            report_mismatch("entry_count", entry_count, want.count);
          end
        end
      end
    end
    outstanding <= predicted_results.size();
  end

endmodule

// ----- dv/testbench.sv -----
module testbench;
  import bole_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS   = 1230;
  localparam int HOLD_AT_ITEM   = 500;
  localparam int HOLD_CYCLES    = 300;
  localparam int CALM_FIRST     = 800;
  localparam int CALM_LAST      = 1000;
  localparam int STALL_LIMIT    = 2000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [OP_W-1:0]        operation = OP_CLEAR;
  logic [VALUE_WIDTH-1:0] item_value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [VALUE_WIDTH-1:0] popped_value;
  logic                   found;
  logic [COUNT_W-1:0]     entry_count;

  int mismatches;
  int outstanding;
  int sent_count = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  logic [VALUE_WIDTH-1:0] value_pool[16];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bounded_ordered_list_engine dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .item_value  (item_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .popped_value(popped_value),
    .found       (found),
    .entry_count (entry_count)
  );

  bole_list_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .item_value  (item_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .popped_value(popped_value),
    .found       (found),
    .entry_count (entry_count),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  task automatic send_request(input logic [OP_W-1:0] op, input logic [VALUE_WIDTH-1:0] value);
    calm = (sent_count >= CALM_FIRST) && (sent_count < CALM_LAST);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    item_value <= value;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    sent_count++;
    if (sent_count == HOLD_AT_ITEM) begin
      hold_req = 1'b1;
    end
  endtask

  function automatic logic [VALUE_WIDTH-1:0] pick_value(input bit allow_zero);
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      return value_pool[$urandom_range(15)];
    end else if (pick < 92 || !allow_zero) begin
      return $urandom() | VALUE_WIDTH'(!allow_zero);
    end
    return '0;
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) return OP_PUSH_FRONT;
    if (pick < 40) return OP_PUSH_BACK;
    if (pick < 52) return OP_POP_FRONT;
    if (pick < 64) return OP_POP_BACK;
    if (pick < 78) return OP_REMOVE;
    if (pick < 94) return OP_FIND;
    if (pick < 97) return OP_CLEAR;
    return OP_UNUSED;
  endfunction

  // The receiver stalls at random, except for one long hold-off that lets the
  // block fill up and stall its input while requests keep coming.
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 15);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int episode;
    int burst;
    for (int i = 0; i < 16; i++) begin
      value_pool[i] = (i < 4) ? VALUE_WIDTH'(i + 1) : $urandom();
      if (value_pool[i] == '0) begin
        value_pool[i] = 32'h0000_0100;
      end
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(OP_POP_FRONT, 32'h0000_0000);
    send_request(OP_POP_BACK, 32'hFFFF_FFFF);
    send_request(OP_FIND, 32'h0000_0005);
    send_request(OP_REMOVE, 32'h0000_0005);
    send_request(OP_PUSH_FRONT, 32'h0000_0000);
    send_request(OP_PUSH_BACK, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h0000_0000);
    send_request(OP_FIND, 32'h0000_0000);
    send_request(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_request(OP_PUSH_BACK, 32'h0000_0001);
    send_request(OP_PUSH_FRONT, 32'h8000_0000);
    send_request(OP_PUSH_BACK, 32'h0000_0007);
    send_request(OP_PUSH_BACK, 32'hFFFF_FFFF);
    send_request(OP_FIND, 32'hFFFF_FFFF);
    send_request(OP_FIND, 32'h0001_2345);
    send_request(OP_REMOVE, 32'h0001_2345);
    send_request(OP_REMOVE, 32'hFFFF_FFFF);
    send_request(OP_FIND, 32'hFFFF_FFFF);
    send_request(OP_UNUSED, 32'hAAAA_AAAA);
    send_request(OP_POP_FRONT, 32'h5555_5555);
    send_request(OP_POP_BACK, 32'h0000_0000);
    send_request(OP_CLEAR, 32'h5555_5555);
    send_request(OP_POP_BACK, 32'h0000_0000);

    while (sent_count < RANDOM_ITEMS + 23) begin
      episode = $urandom_range(99);
      if (episode < 15) begin
        burst = $urandom_range(72, 64);
        repeat (burst) begin
          send_request($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value(1'b0));
        end
      end else if (episode < 25) begin
        burst = $urandom_range(70, 60);
        repeat (burst) begin
          send_request($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT, pick_value(1'b1));
        end
      end else if (episode < 28) begin
        send_request(OP_CLEAR, $urandom());
      end else begin
        burst = $urandom_range(60, 20);
        repeat (burst) begin
          send_request(pick_op(), pick_value(1'b1));
        end
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
